// ===== hdl/aabbpp_pkg.sv =====
// Shared widths, field offsets and types for the box pair penetration block.
// No dependencies; used by the top level, the root pipeline and the checker.
`timescale 1ns / 1ps

package aabbpp_pkg;

  // Field widths
  localparam int unsigned CENTER_W = 24;
  localparam int unsigned SIZE_W   = 23;
  localparam int unsigned DIFF_W   = CENTER_W + 1;
  localparam int unsigned SSUM_W   = SIZE_W + 1;
  localparam int unsigned PEN_W    = CENTER_W + 3;
  localparam int unsigned DEPTH_W  = 24;
  localparam int unsigned SQ_W     = 2 * DIFF_W;
  localparam int unsigned ROOT_W   = SQ_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 2;
  localparam int unsigned AXES     = 3;

  // Request word layout, lowest bit first
  localparam int unsigned A_CENTER_LSB = 0;
  localparam int unsigned A_SIZE_LSB   = A_CENTER_LSB + AXES * CENTER_W;
  localparam int unsigned B_CENTER_LSB = A_SIZE_LSB + AXES * SIZE_W;
  localparam int unsigned B_SIZE_LSB   = B_CENTER_LSB + AXES * CENTER_W;
  localparam int unsigned IN_FIELDS_W  = B_SIZE_LSB + AXES * SIZE_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  // Result word layout, lowest bit first
  localparam int unsigned OUT_HIT_BIT     = 0;
  localparam int unsigned OUT_DEPTH_X_LSB = 1;
  localparam int unsigned OUT_DEPTH_Y_LSB = OUT_DEPTH_X_LSB + DEPTH_W;
  localparam int unsigned OUT_DEPTH_Z_LSB = OUT_DEPTH_Y_LSB + DEPTH_W;
  localparam int unsigned OUT_AXIS_LSB    = OUT_DEPTH_Z_LSB + DEPTH_W;
  localparam int unsigned OUT_NEG_BIT     = OUT_AXIS_LSB + 2;
  localparam int unsigned OUT_DIST_LSB    = OUT_NEG_BIT + 1;
  localparam int unsigned OUT_FIELDS_W    = OUT_DIST_LSB + ROOT_W;
  localparam int unsigned OUT_DATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Result fields that ride along the square root pipeline
  typedef struct packed {
    logic               hit;
    logic [DEPTH_W-1:0] depth_x;
    logic [DEPTH_W-1:0] depth_y;
    logic [DEPTH_W-1:0] depth_z;
    axis_e              normal_axis;
    logic               normal_negative;
  } side_t;

endpackage

// ===== hdl/aabbpp_sqrt.sv =====
// Pipelined floor square root, one root bit per stage, with side payload.
// Depends on aabbpp_pkg for widths and the side payload type.
`timescale 1ns / 1ps

module aabbpp_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [aabbpp_pkg::SQ_W-1:0] in_rad_i,
  input  aabbpp_pkg::side_t           in_side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [aabbpp_pkg::ROOT_W-1:0] out_root_o,
  output aabbpp_pkg::side_t           out_side_o
);

  localparam int unsigned N = aabbpp_pkg::ROOT_W;

  logic                            vld_q  [N];
  logic [aabbpp_pkg::ROOT_W-1:0]   root_q [N];
  aabbpp_pkg::side_t               side_q [N];
  logic [aabbpp_pkg::SQ_W-1:0]     rad_q  [N-1];
  logic [aabbpp_pkg::REM_W-1:0]    rem_q  [N-1];

  logic                            rdy    [N+1];

  assign rdy[N]     = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                          vld_in;
    logic [aabbpp_pkg::SQ_W-1:0]   rad_in;
    logic [aabbpp_pkg::REM_W-1:0]  rem_in;
    logic [aabbpp_pkg::ROOT_W-1:0] root_in;
    aabbpp_pkg::side_t             side_in;
    logic [aabbpp_pkg::REM_W+1:0]  trial;
    logic [aabbpp_pkg::REM_W+1:0]  tsub;
    logic [aabbpp_pkg::REM_W+1:0]  rdiff;
    logic                          take;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign rad_in  = in_rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    // Bring down the next two radicand bits and try root*4+1
    always_comb begin
      trial = {rem_in, rad_in[aabbpp_pkg::SQ_W-1 -: 2]};
      tsub  = {2'b00, root_in, 2'b01};
      rdiff = trial - tsub;
      take  = (trial >= tsub);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_in) begin
        root_q[k] <= {root_in[aabbpp_pkg::ROOT_W-2:0], take};
        side_q[k] <= side_in;
      end
    end

    if (k < N - 1) begin : g_carry
      logic [aabbpp_pkg::REM_W-1:0] rem_d;
      logic [aabbpp_pkg::SQ_W-1:0]  rad_d;

      assign rem_d = take ? rdiff[aabbpp_pkg::REM_W-1:0] : trial[aabbpp_pkg::REM_W-1:0];
      assign rad_d = {rad_in[aabbpp_pkg::SQ_W-3:0], 2'b00};

      always_ff @(posedge clk_i) begin
        if (rdy[k] && vld_in) begin
          rem_q[k] <= rem_d;
          rad_q[k] <= rad_d;
        end
      end
    end
  end

  assign out_valid_o = vld_q[N-1];
  assign out_root_o  = root_q[N-1];
  assign out_side_o  = side_q[N-1];

endmodule

// ===== hdl/aabb_pair_penetration.sv =====
// Top level of the box pair overlap and minimum penetration axis block.
// Depends on aabbpp_pkg and instantiates the root pipeline aabbpp_sqrt.
`timescale 1ns / 1ps

// Usage
//   Slave stream s_axis_*: one request per beat, two boxes A and B given as
//   signed Q16.8 centers and unsigned Q15.8 full sizes. A request is taken
//   at a rising edge with s_axis_tvalid and s_axis_tready both high.
//   Master stream m_axis_*: one result per request, in request order: hit
//   flag, per axis penetration, axis of least penetration, normal sign and
//   floor of the distance between the centers. With no hit all fields are 0.
// Pipeline
//   29 register stages: four stages of box arithmetic (differences,
//   penetrations, squares, sum) and 25 square root stages, each resolving
//   one root bit with one 29-bit compare and subtract. One request per
//   cycle is sustained while m_axis_tready is high.
// Reset
//   rst_ni clears every stage valid bit; the pipeline comes up empty and
//   ready. Payload registers are not reset.
// Stall
//   Each stage takes new data when it is empty or the next stage moves, so
//   while m_axis_tready is low the result holds and bubbles further up fill;
//   s_axis_tready drops only when every stage holds a request.

module aabb_pair_penetration (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // a_center_x, a_center_y, a_center_z, a_size_x, a_size_y, a_size_z,
  // b_center_x, b_center_y, b_center_z, b_size_x, b_size_y, b_size_z, zero pad
  input  logic [aabbpp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // hit, depth_x, depth_y, depth_z, normal_axis, normal_negative,
  // center_distance, zero pad
  output logic [aabbpp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CW = aabbpp_pkg::CENTER_W;
  localparam int unsigned SW = aabbpp_pkg::SIZE_W;
  localparam int unsigned DW = aabbpp_pkg::DIFF_W;
  localparam int unsigned PW = aabbpp_pkg::PEN_W;
  localparam int unsigned QW = aabbpp_pkg::SQ_W;
  localparam int unsigned AX = aabbpp_pkg::AXES;

  // Stage handshake: a stage loads when empty or when its successor loads
  logic rdy1, rdy2, rdy3, rdy4, sq_ready;
  logic vld1_q, vld2_q, vld3_q, vld4_q;

  assign rdy1 = !vld1_q || rdy2;
  assign rdy2 = !vld2_q || rdy3;
  assign rdy3 = !vld3_q || rdy4;
  assign rdy4 = !vld4_q || sq_ready;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      if (rdy1) vld1_q <= s_axis_tvalid;
      if (rdy2) vld2_q <= vld1_q;
      if (rdy3) vld3_q <= vld2_q;
      if (rdy4) vld4_q <= vld3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: center difference B - A and summed sizes per axis.
  // Corners are kept at twice the scale, so with d = cb - ca and s = sa + sb:
  //   A.max - B.min = s - 2d,  B.max - A.min = s + 2d.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] diff1_d [AX];
  logic        [SW:0]   ssum1_d [AX];
  logic signed [DW-1:0] diff1_q [AX];
  logic        [SW:0]   ssum1_q [AX];

  always_comb begin
    for (int k = 0; k < AX; k++) begin
      logic [CW-1:0] ca, cb;
      logic [SW-1:0] sa, sb;
      ca = s_axis_tdata[aabbpp_pkg::A_CENTER_LSB + k*CW +: CW];
      sa = s_axis_tdata[aabbpp_pkg::A_SIZE_LSB   + k*SW +: SW];
      cb = s_axis_tdata[aabbpp_pkg::B_CENTER_LSB + k*CW +: CW];
      sb = s_axis_tdata[aabbpp_pkg::B_SIZE_LSB   + k*SW +: SW];
      diff1_d[k] = $signed({cb[CW-1], cb}) - $signed({ca[CW-1], ca});
      ssum1_d[k] = {1'b0, sa} + {1'b0, sb};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      diff1_q <= diff1_d;
      ssum1_q <= ssum1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: both overlaps, strict hit test, penetration, |d| and sign of d.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] pen2_d  [AX];
  logic        [DW-1:0] absd2_d [AX];
  logic                 pos2_d  [AX];
  logic                 hit2_d;
  logic signed [PW-1:0] pen2_q  [AX];
  logic        [DW-1:0] absd2_q [AX];
  logic                 pos2_q  [AX];
  logic                 hit2_q;

  always_comb begin
    hit2_d = 1'b1;
    for (int k = 0; k < AX; k++) begin
      logic signed [PW-1:0] p1, p2, s_ext, d2;
      s_ext = $signed({3'b000, ssum1_q[k]});
      d2    = $signed({diff1_q[k][DW-1], diff1_q[k], 1'b0});
      p1    = s_ext - d2;
      p2    = s_ext + d2;
      pen2_d[k]  = (p1 < p2) ? p1 : p2;
      // A.max > B.min and A.min < B.max, both strict
      hit2_d     = hit2_d && (p1 > 0) && (p2 > 0);
      absd2_d[k] = diff1_q[k][DW-1] ? (~diff1_q[k] + DW'(1)) : diff1_q[k];
      pos2_d[k]  = !diff1_q[k][DW-1] && (diff1_q[k] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && vld1_q) begin
      pen2_q  <= pen2_d;
      absd2_q <= absd2_d;
      pos2_q  <= pos2_d;
      hit2_q  <= hit2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squares of |d|, least penetration axis (ties to x, then y),
  // and the gated result fields. On a hit every penetration is positive, so
  // the depth is the double-scale value shifted down by one.
  // ---------------------------------------------------------------------------
  logic [QW-1:0]     sq3_d [AX];
  aabbpp_pkg::side_t side3_d;
  logic [QW-1:0]     sq3_q [AX];
  aabbpp_pkg::side_t side3_q;

  always_comb begin
    aabbpp_pkg::axis_e axis;
    logic              neg;
    for (int k = 0; k < AX; k++) begin
      sq3_d[k] = absd2_q[k] * absd2_q[k];
    end
    priority if (pen2_q[0] <= pen2_q[1] && pen2_q[0] <= pen2_q[2]) begin
      axis = aabbpp_pkg::AXIS_X;
      neg  = pos2_q[0];
    end else if (pen2_q[1] <= pen2_q[2]) begin
      axis = aabbpp_pkg::AXIS_Y;
      neg  = pos2_q[1];
    end else begin
      axis = aabbpp_pkg::AXIS_Z;
      neg  = pos2_q[2];
    end
    side3_d.hit             = hit2_q;
    side3_d.depth_x         = hit2_q ? pen2_q[0][aabbpp_pkg::DEPTH_W:1] : '0;
    side3_d.depth_y         = hit2_q ? pen2_q[1][aabbpp_pkg::DEPTH_W:1] : '0;
    side3_d.depth_z         = hit2_q ? pen2_q[2][aabbpp_pkg::DEPTH_W:1] : '0;
    side3_d.normal_axis     = hit2_q ? axis : aabbpp_pkg::AXIS_X;
    side3_d.normal_negative = hit2_q && neg;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && vld2_q) begin
      sq3_q   <= sq3_d;
      side3_q <= side3_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: squared center distance; drop it to zero on a miss so the root
  // comes out zero as well.
  // ---------------------------------------------------------------------------
  logic [QW-1:0]     sum4_d;
  logic [QW-1:0]     sum4_q;
  aabbpp_pkg::side_t side4_q;

  assign sum4_d = side3_q.hit ? (sq3_q[0] + sq3_q[1] + sq3_q[2]) : '0;

  always_ff @(posedge clk_i) begin
    if (rdy4 && vld3_q) begin
      sum4_q  <= sum4_d;
      side4_q <= side3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5 to 29: floor square root; its last stage is the output register.
  // ---------------------------------------------------------------------------
  logic [aabbpp_pkg::ROOT_W-1:0] root;
  aabbpp_pkg::side_t             side_out;

  aabbpp_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld4_q),
    .in_ready_o  (sq_ready),
    .in_rad_i    (sum4_q),
    .in_side_i   (side4_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_root_o  (root),
    .out_side_o  (side_out)
  );

  // Pack the result fields, lowest first, zero pad to whole bytes
  assign m_axis_tdata = {
    {(aabbpp_pkg::OUT_DATA_W - aabbpp_pkg::OUT_FIELDS_W){1'b0}},
    root,
    side_out.normal_negative,
    side_out.normal_axis,
    side_out.depth_z,
    side_out.depth_y,
    side_out.depth_x,
    side_out.hit
  };

endmodule

// ===== hdl/aabbpp_checker.sv =====
// Port level checks for aabb_pair_penetration, attached with a bind.
// Depends on aabbpp_pkg for the result word layout.
`timescale 1ns / 1ps

module aabbpp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [aabbpp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned DW = aabbpp_pkg::DEPTH_W;

  logic          hit;
  logic [1:0]    axis;
  logic [DW-1:0] dx, dy, dz;

  assign hit  = m_axis_tdata[aabbpp_pkg::OUT_HIT_BIT];
  assign axis = m_axis_tdata[aabbpp_pkg::OUT_AXIS_LSB +: 2];
  assign dx   = m_axis_tdata[aabbpp_pkg::OUT_DEPTH_X_LSB +: DW];
  assign dy   = m_axis_tdata[aabbpp_pkg::OUT_DEPTH_Y_LSB +: DW];
  assign dz   = m_axis_tdata[aabbpp_pkg::OUT_DEPTH_Z_LSB +: DW];

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Back pressure on requests only comes from a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request side stalled without a stalled result");

  // A miss carries nothing but zeros
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !hit |-> m_axis_tdata[aabbpp_pkg::OUT_DATA_W-1:1] == '0)
    else $error("miss result has nonzero fields");

  // The normal axis names a real axis
  a_axis_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && hit |-> axis != 2'd3)
    else $error("normal axis code out of range");

  // The normal axis carries the least depth
  a_axis_least: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && hit |->
      (axis == aabbpp_pkg::AXIS_X && dx <= dy && dx <= dz) ||
      (axis == aabbpp_pkg::AXIS_Y && dy <= dx && dy <= dz) ||
      (axis == aabbpp_pkg::AXIS_Z && dz <= dx && dz <= dy))
    else $error("normal axis is not the least penetration");

endmodule

bind aabb_pair_penetration aabbpp_checker u_aabbpp_checker (.*);
